>>> rtl/core/pidde_pkg.sv
package pidde_pkg;

    localparam int GAIN_W     = 16;
    localparam int ERR_W      = 16;
    localparam int TIME_W     = 24;
    localparam int DRIVE_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 32;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_PROP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV = 2'd2;

    localparam logic signed [GAIN_W-1:0] PROP_RESET  = 16'sd256;
    localparam logic signed [GAIN_W-1:0] INT_RESET   = 16'sd256;
    localparam logic signed [GAIN_W-1:0] DERIV_RESET = 16'sd0;

    // internal widths
    localparam int ITERM_PROD_W = GAIN_W + TIME_W + 1;
    localparam int ITERM_SHIFT  = 13;
    localparam int ITERM_W      = ITERM_PROD_W - ITERM_SHIFT;
    localparam int DIV_SHIFT    = 29;
    localparam int DIV_N        = GAIN_W + DIV_SHIFT;
    localparam int DIV_CNT_W    = $clog2(DIV_N);
    localparam int DTERM_W      = DIV_N + 1;
    localparam int PI_W         = ITERM_W + 1;
    localparam int SUM_W        = DTERM_W + 2;
    localparam int PROD_W       = DRIVE_W + ERR_W;
    localparam int ACC_W        = PROD_W + 2;
    localparam int Y_SHIFT      = 8;

    localparam logic signed [DRIVE_W-1:0] Q16_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DRIVE_W-1:0] Q16_MIN = 32'sh8000_0000;
    localparam logic signed [SUM_W-1:0]   SUM_MAX = 48'sh0000_7FFF_FFFF;
    localparam logic signed [SUM_W-1:0]   SUM_MIN = 48'shFFFF_8000_0000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ITERM,
        ST_DIV,
        ST_DTERM,
        ST_COEF,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        MUL_A_X0,
        MUL_G_X1,
        MUL_A_X2
    } mul_sel_t;

    typedef struct packed {
        logic     load;
        logic     clear;
        logic     iterm;
        logic     div_start;
        logic     div_step;
        logic     dterm;
        logic     coef;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     acc_add;
        logic     finish;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

    typedef struct packed {
        logic                      sat;
        logic signed [DRIVE_W-1:0] value;
    } clamp_t;

    function automatic clamp_t clamp_q16(input logic signed [SUM_W-1:0] v);
        clamp_t r;
        if (v > SUM_MAX)
        begin
            r.sat   = 1'b1;
            r.value = Q16_MAX;
        end
        else if (v < SUM_MIN)
        begin
            r.sat   = 1'b1;
            r.value = Q16_MIN;
        end
        else
        begin
            r.sat   = 1'b0;
            r.value = v[DRIVE_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/core/pid_difference_equation.sv
// channel   dir  handshake            payload
// s_*       in   s_tvalid / s_tready  tdata: error_sample, elapsed_time; tuser: command
// m_*       out  m_tvalid / m_tready  tdata: drive_value; tuser: saturated
// cfg_*     in   cfg_we               cfg_index, cfg_data
//
// from acceptance a sample word passes ITERM, DIV, DTERM, COEF, MUL0 to MUL3 and DONE before
// a valid result, and the next word is taken back in IDLE; DIV is the bit-serial 2d/t divider
// a clear word zeroes the history in the accepting cycle and gives no result
// reset loads the default gains and zeroes the history
// a stalled result holds the block in its last state until the output frees
module pid_difference_equation (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [pidde_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pidde_pkg::GAIN_W-1:0]         cfg_data,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [pidde_pkg::IN_DATA_W-1:0]      s_tdata,   // error_sample, elapsed_time
    input  logic                                 s_tuser,   // command
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [pidde_pkg::OUT_DATA_W-1:0]     m_tdata,   // drive_value
    output logic                                 m_tuser    // saturated
);

    pidde_pkg::cmd_t    cmd;
    pidde_pkg::status_t status;

    pidde_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .status   (status),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    pidde_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .status    (status)
    );

endmodule

>>> rtl/core/pidde_div.sv
module pidde_div (
    input  logic                              clk,
    input  logic                              start,
    input  logic                              step,
    input  logic [pidde_pkg::GAIN_W-1:0]      dividend_mag,
    input  logic [pidde_pkg::TIME_W-1:0]      divisor,
    output logic [pidde_pkg::DIV_N-1:0]       quotient
);

    localparam int TW = pidde_pkg::TIME_W;
    localparam int QW = pidde_pkg::DIV_N;

    logic [TW-1:0] divisor_reg;
    logic [TW-1:0] rem_reg;
    logic [TW-1:0] rem_next;
    logic [QW-1:0] quo_reg;
    logic [QW-1:0] quo_next;
    logic [TW:0]   rem_shift;
    logic [TW:0]   rem_diff;
    logic          fits;

    // restoring division, one quotient bit per step
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[QW-1]};
        rem_diff  = rem_shift - {1'b0, divisor_reg};
        fits      = (rem_shift >= {1'b0, divisor_reg});
        rem_next  = fits ? rem_diff[TW-1:0] : rem_shift[TW-1:0];
        quo_next  = {quo_reg[QW-2:0], fits};
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            divisor_reg <= divisor;
            rem_reg     <= '0;
            quo_reg     <= {dividend_mag, {pidde_pkg::DIV_SHIFT{1'b0}}};
        end
        else if (step)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign quotient = quo_reg;

endmodule

>>> rtl/core/pidde_datapath.sv
module pidde_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [pidde_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pidde_pkg::GAIN_W-1:0]         cfg_data,
    input  logic [pidde_pkg::IN_DATA_W-1:0]      s_tdata,
    input  pidde_pkg::cmd_t                      cmd,
    input  logic                                 m_tready,
    output logic                                 m_tvalid,
    output logic [pidde_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                                 m_tuser,
    output pidde_pkg::status_t                   status
);

    localparam int GW  = pidde_pkg::GAIN_W;
    localparam int EW  = pidde_pkg::ERR_W;
    localparam int TW  = pidde_pkg::TIME_W;
    localparam int DW  = pidde_pkg::DRIVE_W;
    localparam int IPW = pidde_pkg::ITERM_PROD_W;
    localparam int IW  = pidde_pkg::ITERM_W;
    localparam int QW  = pidde_pkg::DIV_N;
    localparam int DTW = pidde_pkg::DTERM_W;
    localparam int PW  = pidde_pkg::PI_W;
    localparam int SW  = pidde_pkg::SUM_W;
    localparam int MW  = pidde_pkg::PROD_W;
    localparam int AW  = pidde_pkg::ACC_W;
    localparam int YS  = pidde_pkg::Y_SHIFT;

    logic signed [GW-1:0]  gain_p_reg;
    logic signed [GW-1:0]  gain_i_reg;
    logic signed [GW-1:0]  gain_d_reg;

    logic signed [EW-1:0]  x_reg;
    logic [TW-1:0]         t_reg;
    logic signed [EW-1:0]  x1_reg;
    logic signed [EW-1:0]  x2_reg;
    logic signed [DW-1:0]  y1_reg;
    logic signed [DW-1:0]  y2_reg;

    logic signed [IW-1:0]  iterm_reg;
    logic signed [DTW-1:0] dterm_reg;
    logic signed [PW-1:0]  pi_reg;
    logic signed [DW-1:0]  a_reg;
    logic signed [DW-1:0]  g_reg;
    logic signed [MW-1:0]  prod_reg;
    logic signed [AW-1:0]  acc_reg;
    logic                  flag_reg;

    logic                  m_tvalid_reg;
    logic [DW-1:0]         drive_reg;
    logic                  sat_out_reg;

    logic signed [IPW-1:0] iterm_prod;
    logic signed [IPW-1:0] iterm_sum;
    logic signed [IPW-1:0] iterm_shift;
    logic [GW-1:0]         d_mag;
    logic [QW-1:0]         quotient;
    logic signed [DTW-1:0] q_ext;
    logic signed [DTW-1:0] dterm_next;
    logic signed [PW-1:0]  pi_next;
    logic signed [SW-1:0]  sum_a;
    logic signed [SW-1:0]  sum_g;
    pidde_pkg::clamp_t     a_clamp;
    pidde_pkg::clamp_t     g_clamp;
    logic signed [DW-1:0]  mul_coef;
    logic signed [EW-1:0]  mul_err;
    logic signed [AW-1:0]  y_round;
    pidde_pkg::clamp_t     y_clamp;
    logic [TW-1:0]         in_time;

    assign in_time = s_tdata[EW +: TW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg <= pidde_pkg::PROP_RESET;
            gain_i_reg <= pidde_pkg::INT_RESET;
            gain_d_reg <= pidde_pkg::DERIV_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pidde_pkg::CFG_PROP:  gain_p_reg <= cfg_data;
                pidde_pkg::CFG_INT:   gain_i_reg <= cfg_data;
                pidde_pkg::CFG_DERIV: gain_d_reg <= cfg_data;
                default:              ;
            endcase
        end
    end

    // error and drive history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x1_reg <= '0;
            x2_reg <= '0;
            y1_reg <= '0;
            y2_reg <= '0;
        end
        else if (cmd.clear)
        begin
            x1_reg <= '0;
            x2_reg <= '0;
            y1_reg <= '0;
            y2_reg <= '0;
        end
        else if (cmd.finish)
        begin
            x2_reg <= x1_reg;
            x1_reg <= x_reg;
            y2_reg <= y1_reg;
            y1_reg <= y_clamp.value;
        end
    end

    // i*t/2 with round half up
    always_comb
    begin
        iterm_prod  = gain_i_reg * $signed({1'b0, t_reg});
        iterm_sum   = iterm_prod + IPW'(4096);
        iterm_shift = iterm_sum >>> pidde_pkg::ITERM_SHIFT;
    end

    assign d_mag = gain_d_reg[GW-1] ? GW'(-gain_d_reg) : gain_d_reg;

    pidde_div u_div (
        .clk          (clk),
        .start        (cmd.div_start),
        .step         (cmd.div_step),
        .dividend_mag (d_mag),
        .divisor      (t_reg),
        .quotient     (quotient)
    );

    // 2d/t with its sign, and the zero time case
    always_comb
    begin
        q_ext = $signed({1'b0, quotient});
        if (t_reg == '0)
        begin
            if (gain_d_reg > 0)
                dterm_next = DTW'(pidde_pkg::Q16_MAX);
            else if (gain_d_reg < 0)
                dterm_next = DTW'(pidde_pkg::Q16_MIN);
            else
                dterm_next = '0;
        end
        else if (gain_d_reg[GW-1])
        begin
            dterm_next = -q_ext;
        end
        else
        begin
            dterm_next = q_ext;
        end
        pi_next = PW'($signed({gain_p_reg, 8'b0})) + PW'(iterm_reg);
    end

    always_comb
    begin
        sum_a   = SW'(pi_reg) + SW'(dterm_reg);
        sum_g   = (SW'(iterm_reg) + SW'(dterm_reg)) <<< 1;
        a_clamp = pidde_pkg::clamp_q16(sum_a);
        g_clamp = pidde_pkg::clamp_q16(sum_g);
    end

    // multiplier shared by the three error products
    always_comb
    begin
        unique case (cmd.mul_sel)
            pidde_pkg::MUL_A_X0:
            begin
                mul_coef = a_reg;
                mul_err  = x_reg;
            end
            pidde_pkg::MUL_G_X1:
            begin
                mul_coef = g_reg;
                mul_err  = x1_reg;
            end
            pidde_pkg::MUL_A_X2:
            begin
                mul_coef = a_reg;
                mul_err  = x2_reg;
            end
            default:
            begin
                mul_coef = a_reg;
                mul_err  = x_reg;
            end
        endcase
    end

    always_comb
    begin
        y_round = (acc_reg + AW'(128)) >>> YS;
        y_clamp = pidde_pkg::clamp_q16(SW'(y_round));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg <= s_tdata[EW-1:0];
            t_reg <= in_time;
        end
        if (cmd.iterm)
            iterm_reg <= iterm_shift[IW-1:0];
        if (cmd.dterm)
        begin
            dterm_reg <= dterm_next;
            pi_reg    <= pi_next;
        end
        if (cmd.coef)
        begin
            a_reg   <= a_clamp.value;
            g_reg   <= g_clamp.value;
            acc_reg <= $signed({{(AW-DW-YS){y2_reg[DW-1]}}, y2_reg, {YS{1'b0}}});
        end
        else if (cmd.acc_add)
        begin
            acc_reg <= acc_reg + AW'(prod_reg);
        end
        if (cmd.mul_en)
            prod_reg <= mul_coef * mul_err;
        if (cmd.load)
            flag_reg <= (in_time == '0);
        else if (cmd.coef)
            flag_reg <= flag_reg | a_clamp.sat | g_clamp.sat;
        if (cmd.finish)
        begin
            drive_reg   <= y_clamp.value;
            sat_out_reg <= flag_reg | y_clamp.sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (cmd.finish)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    assign m_tvalid        = m_tvalid_reg;
    assign m_tdata         = drive_reg;
    assign m_tuser         = sat_out_reg;
    assign status.out_free = !m_tvalid_reg || m_tready;

endmodule

>>> rtl/core/pidde_ctrl.sv
module pidde_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tuser,
    input  pidde_pkg::status_t   status,
    output logic                 s_tready,
    output pidde_pkg::cmd_t      cmd
);

    localparam int CW = pidde_pkg::DIV_CNT_W;

    pidde_pkg::state_t state_reg;
    pidde_pkg::state_t state_next;
    logic [CW-1:0]     cnt_reg;
    logic [CW-1:0]     cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pidde_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        s_tready    = 1'b0;
        cmd         = '0;
        cmd.mul_sel = pidde_pkg::MUL_A_X0;
        unique case (state_reg)
            pidde_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (s_tuser)
                    begin
                        cmd.clear = 1'b1;
                    end
                    else
                    begin
                        cmd.load   = 1'b1;
                        state_next = pidde_pkg::ST_ITERM;
                    end
                end
            end
            pidde_pkg::ST_ITERM:
            begin
                cmd.iterm     = 1'b1;
                cmd.div_start = 1'b1;
                cnt_next      = '0;
                state_next    = pidde_pkg::ST_DIV;
            end
            pidde_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CW'(pidde_pkg::DIV_N - 1))
                    state_next = pidde_pkg::ST_DTERM;
            end
            pidde_pkg::ST_DTERM:
            begin
                cmd.dterm  = 1'b1;
                state_next = pidde_pkg::ST_COEF;
            end
            pidde_pkg::ST_COEF:
            begin
                cmd.coef   = 1'b1;
                state_next = pidde_pkg::ST_MUL0;
            end
            pidde_pkg::ST_MUL0:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = pidde_pkg::MUL_A_X0;
                state_next  = pidde_pkg::ST_MUL1;
            end
            pidde_pkg::ST_MUL1:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = pidde_pkg::MUL_G_X1;
                cmd.acc_add = 1'b1;
                state_next  = pidde_pkg::ST_MUL2;
            end
            pidde_pkg::ST_MUL2:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = pidde_pkg::MUL_A_X2;
                cmd.acc_add = 1'b1;
                state_next  = pidde_pkg::ST_MUL3;
            end
            pidde_pkg::ST_MUL3:
            begin
                cmd.acc_add = 1'b1;
                state_next  = pidde_pkg::ST_DONE;
            end
            pidde_pkg::ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = pidde_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pidde_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
